### hw/rtl/mmrd_pkg.sv
package mmrd_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int MIN_FRAME_BYTES = 29;
    localparam int NUM_READINGS = 6;
    localparam int READING_IDX_W = $clog2(NUM_READINGS);
    localparam int CAPTURE_FIRST = 3;
    localparam int CAPTURE_LAST = 26;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h01;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_BAD_ADDRESS = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC = 2'd2;
    localparam logic [1:0] STATUS_SHORT = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } rx_item_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [31:0] voltage;
        logic [31:0] current;
        logic [31:0] power;
        logic [31:0] energy;
        logic [31:0] power_factor;
        logic [31:0] carbon_dioxide;
    } result_item_t;

endpackage

### hw/rtl/mmrd_crc_update.sv
module mmrd_crc_update (
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_updated
);

    always_comb
    begin
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ mmrd_pkg::CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        crc_updated = acc;
    end

endmodule

### hw/rtl/mmrd_frame_core.sv
module mmrd_frame_core #(
    parameter int MAX_FRAME_BYTES = mmrd_pkg::MAX_FRAME_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  mmrd_pkg::rx_item_t     item,
    input  logic [7:0]             device_address,
    output mmrd_pkg::result_item_t result_item
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int IDX_W = mmrd_pkg::READING_IDX_W;

    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [15:0]      recent_reg;
    logic [15:0]      recent_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             match_reg;
    logic             match_next;
    logic [31:0]      readings_reg [mmrd_pkg::NUM_READINGS];
    logic [31:0]      readings_next [mmrd_pkg::NUM_READINGS];

    logic [15:0]      crc_step;
    logic [15:0]      crc_now;
    logic             match_now;
    logic             capture;
    logic [IDX_W-1:0] capture_idx;
    logic [POS_W-1:0] pos_offset;
    logic             frame_short;
    logic             crc_ok;
    logic [1:0]       status;

    mmrd_crc_update u_crc (
        .crc         (crc_reg),
        .data        (recent_reg[15:8]),
        .crc_updated (crc_step)
    );

    // The CRC lags the input by two bytes so the trailing check bytes stay out of it.
    assign crc_now = (pos_reg >= POS_W'(2)) ? crc_step : crc_reg;
    assign match_now = (pos_reg == '0) ? (item.rx_byte == device_address) : match_reg;

    assign capture = (pos_reg >= POS_W'(mmrd_pkg::CAPTURE_FIRST))
                  && (pos_reg <= POS_W'(mmrd_pkg::CAPTURE_LAST));
    assign pos_offset = pos_reg - POS_W'(mmrd_pkg::CAPTURE_FIRST);
    assign capture_idx = IDX_W'(pos_offset >> 2);

    assign frame_short = pos_reg < POS_W'(mmrd_pkg::MIN_FRAME_BYTES - 1);
    assign crc_ok = (crc_now[7:0] == recent_reg[7:0]) && (crc_now[15:8] == item.rx_byte);

    always_comb
    begin
        if (frame_short)
        begin
            status = mmrd_pkg::STATUS_SHORT;
        end
        else if (!match_now)
        begin
            status = mmrd_pkg::STATUS_BAD_ADDRESS;
        end
        else if (!crc_ok)
        begin
            status = mmrd_pkg::STATUS_BAD_CRC;
        end
        else
        begin
            status = mmrd_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        result_item.frame_status = status;
        if (status == mmrd_pkg::STATUS_OK)
        begin
            result_item.voltage        = readings_reg[0];
            result_item.current        = readings_reg[1];
            result_item.power          = readings_reg[2];
            result_item.energy         = readings_reg[3];
            result_item.power_factor   = readings_reg[4];
            result_item.carbon_dioxide = readings_reg[5];
        end
        else
        begin
            result_item.voltage        = '0;
            result_item.current        = '0;
            result_item.power          = '0;
            result_item.energy         = '0;
            result_item.power_factor   = '0;
            result_item.carbon_dioxide = '0;
        end
    end

    always_comb
    begin
        crc_next    = crc_reg;
        recent_next = recent_reg;
        pos_next    = pos_reg;
        match_next  = match_reg;
        if (advance)
        begin
            if (item.frame_end)
            begin
                crc_next    = mmrd_pkg::CRC_INIT;
                recent_next = '0;
                pos_next    = '0;
                match_next  = 1'b0;
            end
            else
            begin
                crc_next    = crc_now;
                recent_next = {recent_reg[7:0], item.rx_byte};
                match_next  = match_now;
                if (pos_reg < POS_W'(MAX_FRAME_BYTES))
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < mmrd_pkg::NUM_READINGS; i++)
        begin
            if (advance && capture && (capture_idx == IDX_W'(i)))
            begin
                readings_next[i] = {readings_reg[i][23:0], item.rx_byte};
            end
            else
            begin
                readings_next[i] = readings_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= mmrd_pkg::CRC_INIT;
            recent_reg <= '0;
            pos_reg    <= '0;
            match_reg  <= 1'b0;
        end
        else
        begin
            crc_reg    <= crc_next;
            recent_reg <= recent_next;
            pos_reg    <= pos_next;
            match_reg  <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mmrd_pkg::NUM_READINGS; i++)
        begin
            readings_reg[i] <= readings_next[i];
        end
    end

endmodule

### hw/rtl/modbus_meter_response_decoder_top.sv
// The result item of a frame is formed when the item that carries the frame end mark leaves
// the input register, and is presented from the result register.
// Throughput: one input item per cycle while rx_stall is low. Each byte passes through the
// input register before it is folded into the frame state; only an end-marked item waits in
// the input register, and only while the result register holds a stalled result.
// Reset (rst_n, asynchronous, active low) clears the frame state, empties both
// registers and sets the expected device address to 1.
module modbus_meter_response_decoder_top #(
    parameter int MAX_FRAME_BYTES = mmrd_pkg::MAX_FRAME_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_wdata,
    input  logic                   rx_valid,
    output logic                   rx_stall,
    input  mmrd_pkg::rx_item_t     rx_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output mmrd_pkg::result_item_t result
);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    mmrd_pkg::rx_item_t     s1_item_reg;
    mmrd_pkg::rx_item_t     s1_item_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    mmrd_pkg::result_item_t res_item_reg;
    mmrd_pkg::result_item_t res_item_next;
    logic [7:0]             address_reg;
    logic [7:0]             address_next;

    mmrd_pkg::result_item_t core_result;
    logic                   out_free;
    logic                   s1_advance;
    logic                   rx_accept;

    assign out_free   = !res_valid_reg || !result_stall;
    assign s1_advance = s1_valid_reg && (!s1_item_reg.frame_end || out_free);
    assign rx_stall   = s1_valid_reg && !s1_advance;
    assign rx_accept  = rx_valid && !rx_stall;

    assign s1_valid_next = rx_accept || (s1_valid_reg && !s1_advance);
    assign s1_item_next  = rx_accept ? rx_item : s1_item_reg;
    assign address_next  = cfg_we ? cfg_wdata : address_reg;

    mmrd_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (s1_advance),
        .item           (s1_item_reg),
        .device_address (address_reg),
        .result_item    (core_result)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;
        if (s1_advance && s1_item_reg.frame_end)
        begin
            res_valid_next = 1'b1;
            res_item_next  = core_result;
        end
        else if (out_free)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            address_reg   <= mmrd_pkg::DEVICE_ADDRESS_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            address_reg   <= address_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg  <= s1_item_next;
        res_item_reg <= res_item_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_item_reg;

endmodule
